// ----- sv/swmt_pkg.sv -----
// swmt_pkg: shared types and codes for the sliding window max tracker
// depends on nothing; imported by swmt_alu and sliding_window_max_tracker_core
package swmt_pkg;

	localparam int unsigned DATA_W = 32;

	typedef logic [DATA_W-1:0] word_t;

	// command codes of the sample channel
	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_RECORD = 1'b1;

	// one deque entry as held in the entry memory
	typedef struct packed {
		word_t size;
		word_t stamp;
	} entry_t;

	// operation select of the shared subtractor
	typedef logic [0:0] alu_op_t;
	localparam alu_op_t ALU_POP = 1'b0; // new sample minus tail size
	localparam alu_op_t ALU_AGE = 1'b1; // current time minus front stamp

	typedef struct packed {
		logic  borrow;
		word_t diff;
	} alu_res_t;

endpackage

// ----- sv/swmt_alu.sv -----
// swmt_alu: the one shared subtractor, used for tail pops and front expiry
// depends on swmt_pkg
module swmt_alu (
	input  swmt_pkg::alu_op_t  op,
	input  swmt_pkg::word_t    sample_size,
	input  swmt_pkg::word_t    now,
	input  swmt_pkg::entry_t   entry,
	output swmt_pkg::alu_res_t res
);
	import swmt_pkg::*;

	word_t            opa;
	word_t            opb;
	logic [DATA_W:0]  full_diff;

	always_comb begin
		unique case (op)
			ALU_POP: begin
				opa = sample_size;
				opb = entry.size;
			end
			ALU_AGE: begin
				opa = now;
				opb = entry.stamp;
			end
			default: begin
				opa = sample_size;
				opb = entry.size;
			end
		endcase
	end

	// borrow set means opa < opb
	assign full_diff  = {1'b0, opa} - {1'b0, opb};
	assign res.borrow = full_diff[DATA_W];
	assign res.diff   = full_diff[DATA_W-1:0];

endmodule

// ----- sv/sliding_window_max_tracker_core.sv -----
// sliding_window_max_tracker_core: top level of the sliding window max tracker
// depends on swmt_pkg and swmt_alu; holds the entry memory and the sequencer
//
// Tracks the largest sample recorded within the last WINDOW_TICKS time steps
// using a monotonic deque kept in a ring of DEQUE_DEPTH entries (size and
// time stamp each). Each transfer on the sample channel is either a tick
// (command 0, time advances and stale entries at the front expire) or a
// record (command 1, entries at the tail no larger than the new sample are
// popped and the sample is appended). Every input transfer yields exactly
// one result transfer carrying the window maximum (0 when empty), the
// number of entries held and an overflow flag for a record dropped because
// the deque was full. One item is worked on at a time and sample_ready is
// low until it is done; a finished result sits in an output register, so
// the next item is taken while the result still waits for result_ready.
// Work per item: a record reads and compares tail entries (popped ones plus
// the one that stops the scan), then appends and checks the front; a tick
// examines front entries (expired ones plus the one that stays). An item
// can also wait in S_FINISH for a full output register. Each examined
// entry costs one read step and one compare step, as the entry memory has a
// registered read and there is one shared subtractor. No clearing pass after
// reset is needed, as only entries inside the held range are ever read.
module sliding_window_max_tracker_core #(
	parameter int unsigned WINDOW_TICKS = 64,
	parameter int unsigned DEQUE_DEPTH  = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// sample channel
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic                  command,
	input  swmt_pkg::word_t       sample_size,
	// result channel
	output logic                  result_valid,
	input  logic                  result_ready,
	output swmt_pkg::word_t       window_max,
	output logic [$clog2(DEQUE_DEPTH + 1)-1:0] entries_held,
	output logic                  overflow
);
	import swmt_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEQUE_DEPTH + 1);
	localparam int unsigned PTR_W = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
	localparam int unsigned SUM_W = CNT_W + 1;

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0; // waiting for a sample transfer
	localparam logic [2:0] S_POP_RD  = 3'd1; // read tail entry
	localparam logic [2:0] S_POP_CMP = 3'd2; // compare tail size with new sample
	localparam logic [2:0] S_APPEND  = 3'd3; // write new sample or flag overflow
	localparam logic [2:0] S_EXP_RD  = 3'd4; // read front entry
	localparam logic [2:0] S_EXP_CMP = 3'd5; // check front age, pick up max
	localparam logic [2:0] S_FINISH  = 3'd6; // load output register

	// ring index: (front + offset) mod DEQUE_DEPTH, offset never above depth
	function automatic logic [PTR_W-1:0] ring_add(
		input logic [PTR_W-1:0] base,
		input logic [CNT_W-1:0] offset
	);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(offset);
		if (sum >= SUM_W'(DEQUE_DEPTH)) begin
			sum = sum - SUM_W'(DEQUE_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	logic [2:0]        state_q;
	word_t             size_q;      // sample of the item in work
	word_t             time_q;      // current time
	logic [PTR_W-1:0]  front_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;       // record dropped in this item
	word_t             max_q;       // window max found for this item

	logic              result_valid_q;
	word_t             window_max_q;
	logic [CNT_W-1:0]  entries_held_q;
	logic              overflow_q;
	logic              out_load;

	// entry memory, one port each way, registered read
	entry_t            entry_mem_q [DEQUE_DEPTH];
	entry_t            rd_entry_q;
	logic              mem_we;
	logic              mem_re;
	logic [PTR_W-1:0]  mem_waddr;
	logic [PTR_W-1:0]  mem_raddr;
	entry_t            mem_wdata;

	alu_op_t           alu_op;
	alu_res_t          alu_res;
	logic              full;
	logic              front_expired;

	assign full = (count_q == CNT_W'(DEQUE_DEPTH));

	// read tail while popping, front otherwise
	assign mem_re    = (state_q == S_POP_RD) || (state_q == S_EXP_RD);
	assign mem_raddr = (state_q == S_POP_RD) ? ring_add(front_q, count_q - CNT_W'(1)) : front_q;
	assign mem_we    = (state_q == S_APPEND) && !full;
	assign mem_waddr = ring_add(front_q, count_q);
	assign mem_wdata = '{size: size_q, stamp: time_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_entry_q <= entry_mem_q[mem_raddr];
		end
	end

	// shared subtractor: pop test while scanning the tail, age test at the front
	assign alu_op = (state_q == S_POP_CMP) ? ALU_POP : ALU_AGE;

	swmt_alu u_alu (
		.op          (alu_op),
		.sample_size (size_q),
		.now         (time_q),
		.entry       (rd_entry_q),
		.res         (alu_res)
	);

	// age computed modulo 2^32, so expiry holds across the time wrap
	assign front_expired = (alu_res.diff >= DATA_W'(WINDOW_TICKS));

	assign sample_ready = (state_q == S_IDLE);

	// output register takes a new result when empty or emptied this cycle
	assign out_load = (state_q == S_FINISH) && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			size_q         <= '0;
			time_q         <= '0;
			front_q        <= '0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
			max_q          <= '0;
			result_valid_q <= 1'b0;
			window_max_q   <= '0;
			entries_held_q <= '0;
			overflow_q     <= 1'b0;
		end else begin
			// result taken frees the output register unless a new one lands
			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (sample_valid) begin
						size_q <= sample_size;
						ovf_q  <= 1'b0;
						max_q  <= '0;
						if (command == CMD_TICK) begin
							// tick: advance time, then expire from the front
							time_q  <= time_q + DATA_W'(1);
							state_q <= (count_q != '0) ? S_EXP_RD : S_FINISH;
						end else begin
							// record: front is already in window, go pop the tail
							state_q <= (count_q != '0) ? S_POP_RD : S_APPEND;
						end
					end
				end
				S_POP_RD: begin
					state_q <= S_POP_CMP;
				end
				S_POP_CMP: begin
					// no borrow means tail size <= new sample: drop the tail
					if (!alu_res.borrow) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= (count_q == CNT_W'(1)) ? S_APPEND : S_POP_RD;
					end else begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					// deque still full after pops: sample is dropped
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= S_EXP_RD;
				end
				S_EXP_RD: begin
					state_q <= S_EXP_CMP;
				end
				S_EXP_CMP: begin
					if (front_expired) begin
						front_q <= ring_add(front_q, CNT_W'(1));
						count_q <= count_q - CNT_W'(1);
						if (count_q == CNT_W'(1)) begin
							max_q   <= '0;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_EXP_RD;
						end
					end else begin
						// front is within window and holds the max
						max_q   <= rd_entry_q.size;
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						window_max_q   <= max_q;
						entries_held_q <= count_q;
						overflow_q     <= ovf_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign window_max   = window_max_q;
	assign entries_held = entries_held_q;
	assign overflow     = overflow_q;

endmodule
